// ===== rtl/core/tfbo_pkg.sv =====
// Package for the triple frame buffer ownership tracker.
// Holds buffer count, owner codes, operation and status codes and register map.
// No dependencies.
package tfbo_pkg;

  localparam int NUM_BUFFERS = 3;
  localparam int IDX_W = 2;
  localparam int BYTES_W = 24;
  localparam int COUNT_W = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic [1:0] owner_t;
  typedef logic [1:0] func_t;
  typedef logic [1:0] status_t;
  typedef logic [IDX_W-1:0] index_t;

  localparam owner_t OWN_FREE    = 2'd0;
  localparam owner_t OWN_DMA     = 2'd1;
  localparam owner_t OWN_READY   = 2'd2;
  localparam owner_t OWN_READING = 2'd3;

  localparam func_t FUNC_GRANT   = 2'd0;
  localparam func_t FUNC_FINISH  = 2'd1;
  localparam func_t FUNC_ACQUIRE = 2'd2;
  localparam func_t FUNC_RELEASE = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NONE     = 2'd1;
  localparam status_t ST_BADSTATE = 2'd2;
  localparam status_t ST_NOMATCH  = 2'd3;

  localparam index_t NO_INDEX = 2'd3;

  // Register select is address bit 2 (byte addresses 0 and 4).
  localparam logic REG_EXPECTED_BYTES = 1'b0;
  localparam logic REG_CAPTURE_EN     = 1'b1;

  localparam logic [BYTES_W-1:0] EXPECTED_BYTES_RESET = 24'd1280000;

endpackage

// ===== rtl/core/triple_frame_buffer_ownership.sv =====
// Triple frame buffer ownership tracker: one operation register, ownership update and result
// register. Depends on tfbo_pkg.
// The operation register loads at the accepting edge and the result register loads from it
// once the result register is empty or being drained; a stalled waiting result holds it back.
// Throughput: one operation per cycle unless a waiting result is stalled; the owner registers and
// priority picks settle in the single compute stage between operation and result registers.
// Reset: synchronous; all buffers FREE, counters and last size zero, registers at defaults.
module triple_frame_buffer_ownership (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          func,
  input  logic [tfbo_pkg::IDX_W-1:0]          buffer_index,
  input  logic [tfbo_pkg::BYTES_W-1:0]        received_bytes,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [tfbo_pkg::IDX_W-1:0]          granted_index,
  output logic [tfbo_pkg::BYTES_W-1:0]        granted_bytes,
  output logic [tfbo_pkg::COUNT_W-1:0]        frame_total,
  output logic [tfbo_pkg::COUNT_W-1:0]        bad_size_total,
  output logic [tfbo_pkg::BYTES_W-1:0]        last_size,
  output logic                                any_reading,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tfbo_pkg::PADDR_W-1:0]        paddr,
  input  logic [tfbo_pkg::PDATA_W-1:0]        pwdata,
  output logic [tfbo_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  // Configuration registers.
  logic [tfbo_pkg::BYTES_W-1:0] expected_bytes;
  logic                         capture_en;

  // Operation register.
  logic                         s1_valid;
  tfbo_pkg::func_t              s1_func;
  tfbo_pkg::index_t             s1_index;
  logic [tfbo_pkg::BYTES_W-1:0] s1_bytes;

  // Tracker state.
  tfbo_pkg::owner_t             owner      [tfbo_pkg::NUM_BUFFERS];
  tfbo_pkg::owner_t             owner_next [tfbo_pkg::NUM_BUFFERS];
  logic [tfbo_pkg::COUNT_W-1:0] frame_count;
  logic [tfbo_pkg::COUNT_W-1:0] frame_count_next;
  logic [tfbo_pkg::COUNT_W-1:0] bad_count;
  logic [tfbo_pkg::COUNT_W-1:0] bad_count_next;
  logic [tfbo_pkg::BYTES_W-1:0] last_frame_size;
  logic [tfbo_pkg::BYTES_W-1:0] last_frame_size_next;

  tfbo_pkg::status_t            status_next;
  tfbo_pkg::index_t             gidx_next;
  logic [tfbo_pkg::BYTES_W-1:0] gbytes_next;

  logic                         advance;
  logic                         do_step;
  logic                         cfg_write;
  logic [tfbo_pkg::NUM_BUFFERS-1:0] ready_vec;
  logic [tfbo_pkg::NUM_BUFFERS-1:0] reading_vec;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_bytes <= tfbo_pkg::EXPECTED_BYTES_RESET;
      capture_en     <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        tfbo_pkg::REG_EXPECTED_BYTES: expected_bytes <= pwdata[tfbo_pkg::BYTES_W-1:0];
        tfbo_pkg::REG_CAPTURE_EN:     capture_en     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tfbo_pkg::REG_EXPECTED_BYTES:
        prdata = {{(tfbo_pkg::PDATA_W-tfbo_pkg::BYTES_W){1'b0}}, expected_bytes};
      tfbo_pkg::REG_CAPTURE_EN:
        prdata = {{(tfbo_pkg::PDATA_W-1){1'b0}}, capture_en};
      default: prdata = '0;
    endcase
  end

  // The compute stage moves whenever the result register is empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign do_step  = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_func  <= func;
      s1_index <= buffer_index;
      s1_bytes <= received_bytes;
    end
  end

  always_comb begin
    logic             free_hit;
    logic             ready_hit;
    logic             idx_hit;
    tfbo_pkg::index_t free_pick;
    tfbo_pkg::index_t ready_pick;
    tfbo_pkg::owner_t idx_owner;
    logic             size_ok;

    free_hit   = 1'b0;
    ready_hit  = 1'b0;
    idx_hit    = 1'b0;
    free_pick  = tfbo_pkg::NO_INDEX;
    ready_pick = tfbo_pkg::NO_INDEX;
    idx_owner  = tfbo_pkg::OWN_FREE;
    size_ok    = (s1_bytes == expected_bytes);

    // Scan downward so the lowest matching buffer wins.
    for (int i = tfbo_pkg::NUM_BUFFERS - 1; i >= 0; i--) begin
      if (owner[i] == tfbo_pkg::OWN_FREE) begin
        free_hit  = 1'b1;
        free_pick = tfbo_pkg::IDX_W'(i);
      end
      if (owner[i] == tfbo_pkg::OWN_READY) begin
        ready_hit  = 1'b1;
        ready_pick = tfbo_pkg::IDX_W'(i);
      end
    end
    for (int i = 0; i < tfbo_pkg::NUM_BUFFERS; i++) begin
      if (s1_index == tfbo_pkg::IDX_W'(i)) begin
        idx_hit   = 1'b1;
        idx_owner = owner[i];
      end
    end

    owner_next      = owner;
    frame_count_next = frame_count;
    bad_count_next  = bad_count;
    last_frame_size_next = last_frame_size;
    status_next     = tfbo_pkg::ST_OK;
    gidx_next       = tfbo_pkg::NO_INDEX;
    gbytes_next     = '0;

    unique case (s1_func)
      tfbo_pkg::FUNC_GRANT: begin
        if (free_hit || ready_hit) begin
          gidx_next   = free_hit ? free_pick : ready_pick;
          gbytes_next = expected_bytes;
          for (int i = 0; i < tfbo_pkg::NUM_BUFFERS; i++) begin
            if (gidx_next == tfbo_pkg::IDX_W'(i)) begin
              owner_next[i] = tfbo_pkg::OWN_DMA;
            end
          end
        end else begin
          status_next = tfbo_pkg::ST_NONE;
        end
      end
      tfbo_pkg::FUNC_FINISH: begin
        frame_count_next = frame_count + 1'b1;
        last_frame_size_next = s1_bytes;
        if (!size_ok) begin
          bad_count_next = bad_count + 1'b1;
        end
        if (idx_hit && idx_owner == tfbo_pkg::OWN_DMA) begin
          // A complete frame becomes the only READY frame.
          for (int i = 0; i < tfbo_pkg::NUM_BUFFERS; i++) begin
            if (size_ok && owner[i] == tfbo_pkg::OWN_READY) begin
              owner_next[i] = tfbo_pkg::OWN_FREE;
            end
            if (s1_index == tfbo_pkg::IDX_W'(i)) begin
              owner_next[i] = size_ok ? tfbo_pkg::OWN_READY : tfbo_pkg::OWN_FREE;
            end
          end
        end else begin
          status_next = tfbo_pkg::ST_NOMATCH;
        end
      end
      tfbo_pkg::FUNC_ACQUIRE: begin
        if (!capture_en) begin
          status_next = tfbo_pkg::ST_BADSTATE;
        end else if (ready_hit) begin
          gidx_next   = ready_pick;
          gbytes_next = expected_bytes;
          for (int i = 0; i < tfbo_pkg::NUM_BUFFERS; i++) begin
            if (ready_pick == tfbo_pkg::IDX_W'(i)) begin
              owner_next[i] = tfbo_pkg::OWN_READING;
            end
          end
        end else begin
          status_next = tfbo_pkg::ST_NONE;
        end
      end
      tfbo_pkg::FUNC_RELEASE: begin
        if (idx_hit && idx_owner == tfbo_pkg::OWN_READING) begin
          for (int i = 0; i < tfbo_pkg::NUM_BUFFERS; i++) begin
            if (s1_index == tfbo_pkg::IDX_W'(i)) begin
              owner_next[i] = tfbo_pkg::OWN_FREE;
            end
          end
        end else begin
          status_next = tfbo_pkg::ST_NOMATCH;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tfbo_pkg::NUM_BUFFERS; i++) begin
        owner[i] <= tfbo_pkg::OWN_FREE;
      end
      frame_count <= '0;
      bad_count   <= '0;
      last_frame_size <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (do_step) begin
        owner       <= owner_next;
        frame_count <= frame_count_next;
        bad_count   <= bad_count_next;
        last_frame_size <= last_frame_size_next;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      status        <= status_next;
      granted_index <= gidx_next;
      granted_bytes <= gbytes_next;
    end
  end

  // The state only changes with a new result, so it doubles as the result's totals.
  always_comb begin
    for (int i = 0; i < tfbo_pkg::NUM_BUFFERS; i++) begin
      ready_vec[i]   = (owner[i] == tfbo_pkg::OWN_READY);
      reading_vec[i] = (owner[i] == tfbo_pkg::OWN_READING);
    end
  end

  assign frame_total    = frame_count;
  assign bad_size_total = bad_count;
  assign last_size      = last_frame_size;
  assign any_reading    = |reading_vec;

`ifndef SYNTHESIS
  // Finishing a good frame frees older READY frames, so at most one is ever READY.
  a_single_ready: assert property (@(posedge clk) disable iff (rst)
    $countones(ready_vec) <= 1)
    else $error("more than one buffer is READY");

  // A granted buffer always comes with an ok status.
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted_index != tfbo_pkg::NO_INDEX) |-> (status == tfbo_pkg::ST_OK))
    else $error("buffer granted with a failing status");

  // A frame count step leaves the last size equal to the finished frame's byte count.
  a_last_size: assert property (@(posedge clk) disable iff (rst)
    (do_step && s1_func == tfbo_pkg::FUNC_FINISH) |=> (last_size == $past(s1_bytes)))
    else $error("last size not taken from the finished frame");
`endif

endmodule
